// ===== design/dpr_pkg.sv =====
// shared types and constants for the disparity point reprojection block
package dpr_pkg;

  // accumulator width, sized for a subpixel factor of up to 64
  localparam int ACC_W = 54;
  // quotient bits: 17 integer bits and 17 fraction bits (one for rounding)
  localparam int QB = 34;
  localparam int FRAC_EXTRA = 17;
  localparam int REG_COUNT = 8;
  localparam int IDX_W = 4;
  localparam int DATA_W = 64;
  localparam int FIELD_W = 12;
  localparam int LANES = 3;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef logic [REG_COUNT-1:0][DATA_W-1:0] qregs_t;

  // one coordinate on its way through the divider
  typedef struct packed {
    logic [ACC_W:0]   rem;
    logic [ACC_W-1:0] num;
    logic [QB-1:0]    quo;
    logic             neg;
    logic             num_pos;
    logic             num_neg;
    logic             pre_ovf;
  } lane_t;

  // all three coordinates and their shared divisor
  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic [ACC_W-1:0]  den;
    logic              den_zero;
  } div_t;

endpackage

// ===== design/dpr_if.sv =====
// stream and configuration channel interfaces
interface dpr_pix_if;
  logic        valid;
  logic        ready;
  logic [11:0] column;
  logic [11:0] row;
  logic [11:0] disparity;
  modport source (output valid, column, row, disparity, input ready);
  modport sink (input valid, column, row, disparity, output ready);
endinterface

interface dpr_pt_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               overflow_flag;
  modport source (output valid, point_x, point_y, point_z, overflow_flag, input ready);
  modport sink (input valid, point_x, point_y, point_z, overflow_flag, output ready);
endinterface

interface dpr_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/dpr_matrix.sv =====
// disparity clamp and Q matrix product, three register stages
module dpr_matrix #(
  parameter int MIN_DISPARITY = 0,
  parameter int MAX_DISPARITY = 4095,
  parameter int SUBPIXEL_FACTOR = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [dpr_pkg::FIELD_W-1:0]            column,
  input  logic [dpr_pkg::FIELD_W-1:0]            row,
  input  logic [dpr_pkg::FIELD_W-1:0]            disparity,
  input  dpr_pkg::qregs_t                        qregs,
  output logic                                   out_valid,
  output logic signed [3:0][dpr_pkg::ACC_W-1:0]  acc
);

  localparam logic signed [dpr_pkg::ACC_W-1:0] FACTOR = dpr_pkg::ACC_W'(SUBPIXEL_FACTOR);

  function automatic logic signed [31:0] qe(dpr_pkg::qregs_t q, int r, int c);
    return $signed(q[2*r + c/2][32*(c%2) +: 32]);
  endfunction

  function automatic logic signed [44:0] mulq(logic signed [31:0] a, logic [11:0] b);
    logic signed [44:0] ax;
    logic signed [44:0] bx;
    ax = 45'(a);
    bx = $signed({33'b0, b});
    return ax * bx;
  endfunction

  logic                        v1, v2;
  logic signed [3:0][44:0]     p0, p1, p2;
  logic signed [3:0][dpr_pkg::ACC_W-1:0] s2, t2;
  logic [dpr_pkg::FIELD_W-1:0] disp_c;

  // clamp: raise to minimum; MAX_DISPARITY or above goes to minimum
  always_comb begin
    disp_c = disparity;
    if (disparity < dpr_pkg::FIELD_W'(MIN_DISPARITY)) disp_c = dpr_pkg::FIELD_W'(MIN_DISPARITY);
    if ({1'b0, disp_c} >= 13'(MAX_DISPARITY)) disp_c = dpr_pkg::FIELD_W'(MIN_DISPARITY);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  // products, partial sums, scale and add
  // elements of the packed product arrays select as unsigned, so re-sign them
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        p0[r] <= mulq(qe(qregs, r, 0), column);
        p1[r] <= mulq(qe(qregs, r, 1), row);
        p2[r] <= mulq(qe(qregs, r, 2), disp_c);
        s2[r] <= dpr_pkg::ACC_W'($signed(p0[r])) + dpr_pkg::ACC_W'($signed(p1[r]))
               + dpr_pkg::ACC_W'(qe(qregs, r, 3));
        t2[r] <= dpr_pkg::ACC_W'($signed(p2[r]));
        acc[r] <= s2[r] * FACTOR + t2[r];
      end
    end
  end

endmodule

// ===== design/dpr_div_prep.sv =====
// signs, magnitudes and early overflow check ahead of the divider
module dpr_div_prep (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [3:0][dpr_pkg::ACC_W-1:0] acc,
  output logic                                  out_valid,
  output dpr_pkg::div_t                         out_div
);

  localparam int W = dpr_pkg::ACC_W;
  localparam int E = dpr_pkg::FRAC_EXTRA;

  dpr_pkg::div_t     nxt;
  logic [W-1:0]      an;
  logic [W+E-1:0]    den_sh;

  always_comb begin
    nxt = '0;
    nxt.den = acc[3][W-1] ? W'(-acc[3]) : W'(acc[3]);
    nxt.den_zero = (acc[3] == '0);
    den_sh = {nxt.den, {E{1'b0}}};
    an = '0;
    for (int l = 0; l < dpr_pkg::LANES; l++) begin
      an = acc[l][W-1] ? W'(-acc[l]) : W'(acc[l]);
      nxt.lane[l].num = an;
      nxt.lane[l].rem = (W+1)'(an >> E);
      nxt.lane[l].quo = '0;
      nxt.lane[l].neg = acc[l][W-1] ^ acc[3][W-1];
      nxt.lane[l].num_neg = acc[l][W-1];
      nxt.lane[l].num_pos = !acc[l][W-1] && (acc[l] != '0);
      // integer part would not fit in 17 bits
      nxt.lane[l].pre_ovf = ({{E{1'b0}}, an} >= den_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_div <= nxt;
    end
  end

endmodule

// ===== design/dpr_div_step.sv =====
// one restoring division step for all three coordinates
module dpr_div_step #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  dpr_pkg::div_t in_div,
  output logic          out_valid,
  output dpr_pkg::div_t out_div
);

  localparam int W = dpr_pkg::ACC_W;
  localparam int BIT = dpr_pkg::QB - 1 - STEP;

  logic [dpr_pkg::LANES-1:0] nb;
  dpr_pkg::div_t             nxt;
  logic [W:0]                rs;

  // next dividend bit: numerator bits, then zeros for the fraction
  for (genvar l = 0; l < dpr_pkg::LANES; l++) begin : g_bit
    if (BIT >= dpr_pkg::FRAC_EXTRA) begin : g_num
      assign nb[l] = in_div.lane[l].num[BIT - dpr_pkg::FRAC_EXTRA];
    end else begin : g_zero
      assign nb[l] = 1'b0;
    end
  end

  always_comb begin
    nxt = in_div;
    rs = '0;
    for (int l = 0; l < dpr_pkg::LANES; l++) begin
      rs = {in_div.lane[l].rem[W-1:0], nb[l]};
      if (rs >= {1'b0, in_div.den}) begin
        nxt.lane[l].rem = rs - {1'b0, in_div.den};
        nxt.lane[l].quo[BIT] = 1'b1;
      end else begin
        nxt.lane[l].rem = rs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_div <= nxt;
    end
  end

endmodule

// ===== design/dpr_result.sv =====
// rounding, saturation and the output register
module dpr_result (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  dpr_pkg::div_t in_div,
  output logic          out_valid,
  output logic [dpr_pkg::LANES-1:0][31:0] point,
  output logic          ovf
);

  logic [dpr_pkg::LANES-1:0][31:0] val;
  logic [dpr_pkg::LANES-1:0]       lov;
  logic [dpr_pkg::QB:0]            mag;

  // round half away from zero, then saturate
  always_comb begin
    mag = '0;
    for (int l = 0; l < dpr_pkg::LANES; l++) begin
      mag = ({1'b0, in_div.lane[l].quo} + 1'b1) >> 1;
      lov[l] = 1'b0;
      val[l] = '0;
      if (in_div.den_zero) begin
        lov[l] = 1'b1;
        if (in_div.lane[l].num_pos) val[l] = dpr_pkg::SAT_POS;
        else if (in_div.lane[l].num_neg) val[l] = dpr_pkg::SAT_NEG;
      end else if (in_div.lane[l].pre_ovf) begin
        lov[l] = 1'b1;
        val[l] = in_div.lane[l].neg ? dpr_pkg::SAT_NEG : dpr_pkg::SAT_POS;
      end else if (in_div.lane[l].neg) begin
        if (mag > (dpr_pkg::QB+1)'(dpr_pkg::SAT_NEG)) begin
          lov[l] = 1'b1;
          val[l] = dpr_pkg::SAT_NEG;
        end else begin
          val[l] = 32'(-mag);
        end
      end else begin
        if (mag > (dpr_pkg::QB+1)'(dpr_pkg::SAT_POS)) begin
          lov[l] = 1'b1;
          val[l] = dpr_pkg::SAT_POS;
        end else begin
          val[l] = mag[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      point <= val;
      ovf <= |lov;
    end
  end

endmodule

// ===== design/disparity_point_reprojection.sv =====
// Stereo disparity to 3-D point reprojection, one pixel per clock.
// pix_in takes a transaction of column, row and raw disparity; pt_out gives
// X/W, Y/W, Z/W in signed Q16.16 plus an overflow flag for each pixel, in
// order. The Q matrix (signed Q12.20) sits in eight 64-bit registers written
// through cfg, which is always ready; write only while the pipeline is empty.
// An accepted pixel reaches its point on pt_out through these stages in order:
// three stages of clamp and matrix product, one stage of sign and range
// prep, 34 restoring division steps (one quotient bit each, three lanes
// sharing the W divisor), and the rounding/saturation output register.
// Throughput is one pixel per cycle. The whole pipeline advances together:
// when pt_out holds a point and the receiver is not ready, every stage
// holds and pix_in.ready drops, so nothing is lost or repeated.
// Reset clears all valid bits and the matrix registers to zero; with a zero
// matrix W is zero, so every point comes out flagged.
module disparity_point_reprojection #(
  parameter int MIN_DISPARITY = 0,
  parameter int MAX_DISPARITY = 4095,
  parameter int SUBPIXEL_FACTOR = 16
) (
  input logic         clk,
  input logic         rst,
  dpr_cfg_if.sink     cfg,
  dpr_pix_if.sink     pix_in,
  dpr_pt_if.source    pt_out
);

  localparam int QB = dpr_pkg::QB;

  logic                                   en;
  dpr_pkg::qregs_t                        qregs;
  logic                                   acc_valid;
  logic signed [3:0][dpr_pkg::ACC_W-1:0]  acc;
  logic [QB:0]                            dv;
  dpr_pkg::div_t [QB:0]                   dd;
  logic [dpr_pkg::LANES-1:0][31:0]        point;

  // global advance
  assign en = !pt_out.valid || pt_out.ready;
  assign pix_in.ready = en;
  assign cfg.ready = 1'b1;

  // matrix registers
  always_ff @(posedge clk) begin
    if (rst) begin
      qregs <= '0;
    end else if (cfg.valid && cfg.index < dpr_pkg::IDX_W'(dpr_pkg::REG_COUNT)) begin
      qregs[cfg.index[2:0]] <= cfg.data;
    end
  end

  dpr_matrix #(
    .MIN_DISPARITY(MIN_DISPARITY),
    .MAX_DISPARITY(MAX_DISPARITY),
    .SUBPIXEL_FACTOR(SUBPIXEL_FACTOR)
  ) u_matrix (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(pix_in.valid),
    .column(pix_in.column), .row(pix_in.row), .disparity(pix_in.disparity),
    .qregs(qregs),
    .out_valid(acc_valid), .acc(acc)
  );

  dpr_div_prep u_prep (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(acc_valid), .acc(acc),
    .out_valid(dv[0]), .out_div(dd[0])
  );

  // divider chain
  for (genvar s = 0; s < QB; s++) begin : g_div
    dpr_div_step #(.STEP(s)) u_step (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(dv[s]), .in_div(dd[s]),
      .out_valid(dv[s+1]), .out_div(dd[s+1])
    );
  end

  dpr_result u_result (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(dv[QB]), .in_div(dd[QB]),
    .out_valid(pt_out.valid), .point(point), .ovf(pt_out.overflow_flag)
  );

  assign pt_out.point_x = $signed(point[0]);
  assign pt_out.point_y = $signed(point[1]);
  assign pt_out.point_z = $signed(point[2]);

endmodule

// ===== design/dpr_checker.sv =====
// port-level checks for the reprojection block, bound to the top level
module dpr_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_ready,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic        out_ovf
);

  // pipeline takes input exactly when the output side can move
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // a stalled point holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_ovf))
    else $error("stalled point changed");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("point valid right after reset");

  // configuration never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration channel stalled");

endmodule

bind disparity_point_reprojection dpr_checker u_dpr_checker (
  .clk(clk),
  .rst(rst),
  .cfg_ready(cfg.ready),
  .in_ready(pix_in.ready),
  .out_valid(pt_out.valid),
  .out_ready(pt_out.ready),
  .out_x(pt_out.point_x),
  .out_ovf(pt_out.overflow_flag)
);
